// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/csg_pkg.sv -----
package csg_pkg;

    // field widths
    localparam int OP_W       = 3;
    localparam int COORD_W    = 16;
    localparam int RW_W       = 15;
    localparam int SUB_W      = 4;
    localparam int COLOR_W    = 32;
    localparam int POS_OUT_W  = 12;
    localparam int LEN_W      = 13;
    localparam int DIM_W      = 13;

    // internal coordinate width, holds start + size + step
    localparam int CW         = 18;

    // divider
    localparam int DIV_STEPS  = RW_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]     SURF_RESET = 13'd1024;

    // opcodes
    localparam logic [OP_W-1:0] OP_DOT  = 3'd0;
    localparam logic [OP_W-1:0] OP_HL   = 3'd1;
    localparam logic [OP_W-1:0] OP_VL   = 3'd2;
    localparam logic [OP_W-1:0] OP_RECT = 3'd3;
    localparam logic [OP_W-1:0] OP_GRID = 3'd4;

    // span jobs selected by the controller
    typedef logic [3:0] t_job;
    localparam t_job J_NONE  = 4'd0;
    localparam t_job J_DOT   = 4'd1;
    localparam t_job J_HL    = 4'd2;
    localparam t_job J_VL    = 4'd3;
    localparam t_job J_RTOP  = 4'd4;
    localparam t_job J_RBOT  = 4'd5;
    localparam t_job J_RLEFT = 4'd6;
    localparam t_job J_RRGT  = 4'd7;
    localparam t_job J_GV    = 4'd8;
    localparam t_job J_GH    = 4'd9;

    // grid cursor operations
    typedef logic [1:0] t_cur_op;
    localparam t_cur_op CUR_HOLD   = 2'd0;
    localparam t_cur_op CUR_LOAD_X = 2'd1;
    localparam t_cur_op CUR_LOAD_Y = 2'd2;
    localparam t_cur_op CUR_STEP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] end_coord;
        logic [RW_W-1:0]           rect_w;
        logic [RW_W-1:0]           rect_h;
        logic [SUB_W-1:0]          subdivisions;
        logic [COLOR_W-1:0]        color;
    } t_req;

    typedef struct packed {
        logic [POS_OUT_W-1:0] span_x;
        logic [POS_OUT_W-1:0] span_y;
        logic [LEN_W-1:0]     span_len;
        logic                 vertical;
        logic [COLOR_W-1:0]   span_color;
        logic                 bad_request;
        logic                 last;
    } t_span;

    typedef struct packed {
        logic    load;
        logic    div_step;
        t_job    job;
        logic    span_eval;
        logic    flush;
        logic    emit_err;
        t_cur_op cur_op;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic grid_bad;
        logic loop_end;
    } t_sts;

endpackage

// ----- rtl/csg_ctrl.sv -----
module csg_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [csg_pkg::OP_W-1:0]  i_opcode,
    input  csg_pkg::t_sts             i_sts,
    output csg_pkg::t_cmd             o_cmd,
    output logic                      o_busy
);
    import csg_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DOT   = 4'd1;
    localparam logic [3:0] ST_HL    = 4'd2;
    localparam logic [3:0] ST_VL    = 4'd3;
    localparam logic [3:0] ST_RTOP  = 4'd4;
    localparam logic [3:0] ST_RBOT  = 4'd5;
    localparam logic [3:0] ST_RLEFT = 4'd6;
    localparam logic [3:0] ST_RRGT  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_GCHK  = 4'd9;
    localparam logic [3:0] ST_GV    = 4'd10;
    localparam logic [3:0] ST_GH    = 4'd11;
    localparam logic [3:0] ST_ERR   = 4'd12;
    localparam logic [3:0] ST_FLUSH = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_opcode)
                        OP_DOT:  n_state = ST_DOT;
                        OP_HL:   n_state = ST_HL;
                        OP_VL:   n_state = ST_VL;
                        OP_RECT: n_state = ST_RTOP;
                        OP_GRID: n_state = ST_DIV;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DOT: begin
                o_cmd.job       = J_DOT;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_FLUSH;
            end
            ST_HL: begin
                o_cmd.job       = J_HL;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_FLUSH;
            end
            ST_VL: begin
                o_cmd.job       = J_VL;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_FLUSH;
            end
            ST_RTOP: begin
                o_cmd.job       = J_RTOP;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_RBOT;
            end
            ST_RBOT: begin
                o_cmd.job       = J_RBOT;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_RLEFT;
            end
            ST_RLEFT: begin
                o_cmd.job       = J_RLEFT;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_RRGT;
            end
            ST_RRGT: begin
                o_cmd.job       = J_RRGT;
                o_cmd.span_eval = 1'b1;
                n_state         = ST_FLUSH;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_GCHK;
                end
            end
            ST_GCHK: begin
                if (i_sts.grid_bad) begin
                    n_state = ST_ERR;
                end else begin
                    o_cmd.cur_op = CUR_LOAD_X;
                    n_state      = ST_GV;
                end
            end
            ST_GV: begin
                o_cmd.job       = J_GV;
                o_cmd.span_eval = 1'b1;
                if (i_sts.loop_end) begin
                    o_cmd.cur_op = CUR_LOAD_Y;
                    n_state      = ST_GH;
                end else begin
                    o_cmd.cur_op = CUR_STEP;
                end
            end
            ST_GH: begin
                o_cmd.job       = J_GH;
                o_cmd.span_eval = 1'b1;
                if (i_sts.loop_end) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.cur_op = CUR_STEP;
                end
            end
            ST_ERR: begin
                o_cmd.emit_err = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ----- rtl/csg_dpath.sv -----
module csg_dpath #(
    parameter int MAX_SURFACE_DIM  = 4096,
    parameter int MAX_SUBDIVISIONS = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [csg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [csg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  csg_pkg::t_req                   i_req,
    input  csg_pkg::t_cmd                   i_cmd,
    output csg_pkg::t_sts                   o_sts,
    output logic                            o_span_valid,
    output csg_pkg::t_span                  o_span
);
    import csg_pkg::*;

    // surface registers
    logic [DIM_W-1:0] r_surf_w;
    logic [DIM_W-1:0] r_surf_h;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;

    // held request
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic signed [CW-1:0] r_ec;
    logic signed [CW-1:0] r_xe;
    logic signed [CW-1:0] r_ye;
    logic [SUB_W-1:0]     r_sub;
    logic [COLOR_W-1:0]   r_color;

    // step dividers, quotient builds up in the dividend register
    logic [RW_W-1:0]      r_qx;
    logic [RW_W-1:0]      r_qy;
    logic [SUB_W-1:0]     r_remx;
    logic [SUB_W-1:0]     r_remy;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [SUB_W:0]       remx_sh;
    logic [SUB_W:0]       remy_sh;
    logic                 gex;
    logic                 gey;

    // grid cursor
    logic signed [CW-1:0] r_cur;
    logic signed [CW-1:0] c_next;
    logic signed [CW-1:0] end_sel;
    logic [RW_W-1:0]      step_sel;

    // span evaluation
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a2;
    logic signed [CW-1:0] fx;
    logic                 vert;
    logic                 strict;
    logic [DIM_W-1:0]     lim_a;
    logic [DIM_W-1:0]     lim_f;
    logic signed [CW-1:0] lim_a_s;
    logic signed [CW-1:0] lim_f_s;
    logic signed [CW-1:0] top_s;
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] len;
    logic                 sp_ok;
    t_span                sp_new;
    t_span                err_span;
    t_span                pend_fin;

    // pending span and output register
    logic  r_pend_valid;
    t_span r_pend;
    logic  r_out_valid;
    t_span r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= SURF_RESET;
            r_surf_h <= SURF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_surf_w <= i_cfg_data;
                CFG_HEIGHT: r_surf_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate surface size
    assign dim_w = (32'(r_surf_w) > MAX_SURFACE_DIM) ? DIM_W'(MAX_SURFACE_DIM) : r_surf_w;
    assign dim_h = (32'(r_surf_h) > MAX_SURFACE_DIM) ? DIM_W'(MAX_SURFACE_DIM) : r_surf_h;

    // request capture and far edges
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px    <= $signed({{(CW-COORD_W){i_req.pos_x[COORD_W-1]}}, i_req.pos_x});
            r_py    <= $signed({{(CW-COORD_W){i_req.pos_y[COORD_W-1]}}, i_req.pos_y});
            r_ec    <= $signed({{(CW-COORD_W){i_req.end_coord[COORD_W-1]}}, i_req.end_coord});
            r_xe    <= $signed({{(CW-COORD_W){i_req.pos_x[COORD_W-1]}}, i_req.pos_x})
                     + $signed({{(CW-RW_W){1'b0}}, i_req.rect_w});
            r_ye    <= $signed({{(CW-COORD_W){i_req.pos_y[COORD_W-1]}}, i_req.pos_y})
                     + $signed({{(CW-RW_W){1'b0}}, i_req.rect_h});
            r_sub   <= i_req.subdivisions;
            r_color <= i_req.color;
        end
    end

    // restoring division, one quotient bit per cycle on each axis
    assign remx_sh = {r_remx, r_qx[RW_W-1]};
    assign remy_sh = {r_remy, r_qy[RW_W-1]};
    assign gex     = (remx_sh >= {1'b0, r_sub});
    assign gey     = (remy_sh >= {1'b0, r_sub});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx   <= i_req.rect_w;
            r_qy   <= i_req.rect_h;
            r_remx <= '0;
            r_remy <= '0;
        end else if (i_cmd.div_step) begin
            r_qx   <= {r_qx[RW_W-2:0], gex};
            r_qy   <= {r_qy[RW_W-2:0], gey};
            r_remx <= gex ? SUB_W'(remx_sh - {1'b0, r_sub}) : remx_sh[SUB_W-1:0];
            r_remy <= gey ? SUB_W'(remy_sh - {1'b0, r_sub}) : remy_sh[SUB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    // grid cursor advance
    assign step_sel = (i_cmd.job == J_GH) ? r_qy : r_qx;
    assign end_sel  = (i_cmd.job == J_GH) ? r_ye : r_xe;
    assign c_next   = r_cur + $signed({{(CW-RW_W){1'b0}}, step_sel});

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cur_op)
            CUR_HOLD:   r_cur <= r_cur;
            CUR_LOAD_X: r_cur <= r_px;
            CUR_LOAD_Y: r_cur <= r_py;
            CUR_STEP:   r_cur <= c_next;
            default:    r_cur <= r_cur;
        endcase
    end

    // status to the controller
    always_comb begin
        o_sts.div_last = (r_div_cnt == '0);
        o_sts.grid_bad = (r_sub == '0) || (32'(r_sub) > MAX_SUBDIVISIONS)
                       || (r_qx == '0) || (r_qy == '0);
        o_sts.loop_end = (c_next > end_sel);
    end

    // span endpoints for the current job
    always_comb begin
        a1     = r_px;
        a2     = r_px;
        fx     = r_py;
        vert   = 1'b0;
        strict = 1'b0;
        unique case (i_cmd.job)
            J_DOT: begin
                strict = 1'b1;
            end
            J_HL: begin
                a2 = r_ec;
            end
            J_VL: begin
                a1   = r_py;
                a2   = r_ec;
                fx   = r_px;
                vert = 1'b1;
            end
            J_RTOP: begin
                a2 = r_xe;
            end
            J_RBOT: begin
                a2 = r_xe;
                fx = r_ye;
            end
            J_RLEFT: begin
                a1   = r_py;
                a2   = r_ye;
                fx   = r_px;
                vert = 1'b1;
            end
            J_RRGT: begin
                a1   = r_py;
                a2   = r_ye;
                fx   = r_xe;
                vert = 1'b1;
            end
            J_GV: begin
                a1   = r_py;
                a2   = r_ye;
                fx   = r_cur;
                vert = 1'b1;
            end
            J_GH: begin
                a2 = r_xe;
                fx = r_cur;
            end
            default: ;
        endcase
    end

    // clip test and clamp of both ends
    always_comb begin
        lim_a   = vert ? dim_h : dim_w;
        lim_f   = vert ? dim_w : dim_h;
        lim_a_s = $signed({{(CW-DIM_W){1'b0}}, lim_a});
        lim_f_s = $signed({{(CW-DIM_W){1'b0}}, lim_f});
        top_s   = CW'(lim_a_s - 1);
        sp_ok   = (lim_a != '0) && (fx >= 0) && (fx < lim_f_s)
                && (!strict || ((a1 >= 0) && (a1 < lim_a_s)));
        ca      = (a1 < 0) ? '0 : ((a1 > top_s) ? top_s : a1);
        cb      = (a2 < 0) ? '0 : ((a2 > top_s) ? top_s : a2);
        lo      = (ca < cb) ? ca : cb;
        hi      = (ca < cb) ? cb : ca;
        len     = CW'(hi - lo + 1);

        sp_new             = '0;
        sp_new.span_x      = vert ? fx[POS_OUT_W-1:0] : lo[POS_OUT_W-1:0];
        sp_new.span_y      = vert ? lo[POS_OUT_W-1:0] : fx[POS_OUT_W-1:0];
        sp_new.span_len    = len[LEN_W-1:0];
        sp_new.vertical    = vert;
        sp_new.span_color  = r_color;

        err_span             = '0;
        err_span.bad_request = 1'b1;
        err_span.last        = 1'b1;

        // held span marked as the final one of its request
        pend_fin      = r_pend;
        pend_fin.last = 1'b1;
    end

    // one-deep hold so the final span can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            priority if (i_cmd.emit_err) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.span_eval && sp_ok) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_err) begin
            r_out <= err_span;
        end else if (i_cmd.flush) begin
            r_out <= pend_fin;
        end else if (i_cmd.span_eval && sp_ok) begin
            r_out  <= r_pend;
            r_pend <= sp_new;
        end
    end

    assign o_span_valid = r_out_valid;
    assign o_span       = r_out;

endmodule

// ----- rtl/clipped_axis_line_span_generator_unit.sv -----
// channel   | transfer when                 | payload
// ----------+-------------------------------+------------------
// request   | start high while busy low     | i_req (t_req)
// result    | o_span_valid high, one cycle  | o_span (t_span)
// config    | i_cfg_we high                 | i_cfg_idx, i_cfg_data
//
// a dot or line keeps busy high through its span state and the flush state, a
// rectangle through its top, bottom, left and right edge states and the flush;
// a grid runs its two restoring dividers and a check, then each candidate span
// (at most 60) in turn and the flush; a grid error takes the error state instead
// each result appears in the cycle after the next span or the flush confirms it,
// so the last one comes in the first cycle with busy low
// synchronous active-low reset, surface size returns to 1024 by 1024
// results cannot be stalled: each is valid for exactly one cycle
`include "assert_macros.svh"

module clipped_axis_line_span_generator_unit #(
    parameter int MAX_SURFACE_DIM  = 4096,
    parameter int MAX_SUBDIVISIONS = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  csg_pkg::t_req                   i_req,
    output logic                            o_span_valid,
    output csg_pkg::t_span                  o_span,
    input  logic                            i_cfg_we,
    input  logic [csg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [csg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import csg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    csg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // clip, divide and output path
    csg_dpath #(
        .MAX_SURFACE_DIM  (MAX_SURFACE_DIM),
        .MAX_SUBDIVISIONS (MAX_SUBDIVISIONS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_span_valid (o_span_valid),
        .o_span       (o_span)
    );

    // checks
    `ASSERT_IMP(a_out_busy, i_clk, i_rst_n, o_span_valid, $past(busy))
    `ASSERT_IMP(a_err_shape, i_clk, i_rst_n, o_span_valid && o_span.bad_request, o_span.last && (o_span.span_len == '0))
    `ASSERT_IMP(a_span_len, i_clk, i_rst_n, o_span_valid && !o_span.bad_request, o_span.span_len != '0)
    `ASSERT_NXT(a_last_gap, i_clk, i_rst_n, o_span_valid && o_span.last, !o_span_valid)
    `ASSERT_IMP(a_div_seq, i_clk, i_rst_n, cmd.div_step, $past(cmd.div_step) || $past(cmd.load))

endmodule

// ----- tb/clipped_axis_line_span_generator_unit_tb.sv -----
module clipped_axis_line_span_generator_unit_tb;

    import csg_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int MAX_SUB        = 15;
    localparam int MAX_SPANS      = 64;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 100;
    localparam int TIMEOUT        = 10_000_000;
    localparam int PRINT_LIMIT    = 50;
    localparam int SETTINGS_PER   = 4;
    localparam int ITEMS_PER      = 38;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_req                   i_req = '0;
    logic                   o_span_valid;
    t_span                  o_span;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // own copy of the surface size, as the block holds it
    logic [DIM_W-1:0] surf_w_reg = SURF_RESET;
    logic [DIM_W-1:0] surf_h_reg = SURF_RESET;

    t_span pending_spans[$];
    t_span req_spans[$];
    int    mismatch_count = 0;
    int    sender_idle_pct = 0;

    clipped_axis_line_span_generator_unit #(
        .MAX_SURFACE_DIM  (MAX_DIM),
        .MAX_SUBDIVISIONS (MAX_SUB)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_span_valid (o_span_valid),
        .o_span       (o_span),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #TIMEOUT;
        $display("clipped_axis_line_span_generator_unit_tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // span prediction
    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic int clamp_coord(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void push_span(input int x, input int y, input int len,
                                      input logic vert, input logic [COLOR_W-1:0] colour,
                                      input logic bad);
        t_span s;
        if (req_spans.size() >= MAX_SPANS) return;
        s.span_x      = POS_OUT_W'(x);
        s.span_y      = POS_OUT_W'(y);
        s.span_len    = LEN_W'(len);
        s.vertical    = vert;
        s.span_color  = colour;
        s.bad_request = bad;
        s.last        = 1'b0;
        req_spans.push_back(s);
    endfunction

    // clamped horizontal span, dropped when its row is off the surface
    function automatic void add_hspan(input int x1, input int x2, input int y,
                                      input logic [COLOR_W-1:0] colour);
        int w, h, a, b;
        w = eff_dim(surf_w_reg);
        h = eff_dim(surf_h_reg);
        if (w == 0 || y < 0 || y >= h) return;
        a = clamp_coord(x1, 0, w - 1);
        b = clamp_coord(x2, 0, w - 1);
        push_span((a < b) ? a : b, y, ((a < b) ? b - a : a - b) + 1, 1'b0, colour, 1'b0);
    endfunction

    // clamped vertical span, dropped when its column is off the surface
    function automatic void add_vspan(input int y1, input int y2, input int x,
                                      input logic [COLOR_W-1:0] colour);
        int w, h, a, b;
        w = eff_dim(surf_w_reg);
        h = eff_dim(surf_h_reg);
        if (h == 0 || x < 0 || x >= w) return;
        a = clamp_coord(y1, 0, h - 1);
        b = clamp_coord(y2, 0, h - 1);
        push_span(x, (a < b) ? a : b, ((a < b) ? b - a : a - b) + 1, 1'b1, colour, 1'b0);
    endfunction

    function automatic void predict_spans(input t_req r);
        int px, py, ec, rw, rh, sub, stx, sty, c, w, h;
        req_spans.delete();
        px  = $signed(r.pos_x);
        py  = $signed(r.pos_y);
        ec  = $signed(r.end_coord);
        rw  = int'(r.rect_w);
        rh  = int'(r.rect_h);
        sub = int'(r.subdivisions);
        w   = eff_dim(surf_w_reg);
        h   = eff_dim(surf_h_reg);
        case (r.opcode)
            OP_DOT: begin
                if (px >= 0 && px < w && py >= 0 && py < h)
                    push_span(px, py, 1, 1'b0, r.color, 1'b0);
            end
            OP_HL: add_hspan(px, ec, py, r.color);
            OP_VL: add_vspan(py, ec, px, r.color);
            OP_RECT: begin
                add_hspan(px, px + rw, py, r.color);
                add_hspan(px, px + rw, py + rh, r.color);
                add_vspan(py, py + rh, px, r.color);
                add_vspan(py, py + rh, px + rw, r.color);
            end
            OP_GRID: begin
                stx = 0;
                sty = 0;
                if (sub > 0 && sub <= MAX_SUB) begin
                    stx = rw / sub;
                    sty = rh / sub;
                end
                if (stx == 0 || sty == 0) begin
                    push_span(0, 0, 0, 1'b0, '0, 1'b1);
                end else begin
                    for (c = px; c <= px + rw; c += stx)
                        add_vspan(py, py + rh, c, r.color);
                    for (c = py; c <= py + rh; c += sty)
                        add_hspan(px, px + rw, c, r.color);
                end
            end
            default: ;
        endcase
        if (req_spans.size() > 0)
            req_spans[req_spans.size() - 1].last = 1'b1;
        foreach (req_spans[i])
            pending_spans.push_back(req_spans[i]);
    endfunction

    // one request transfer, with random idle cycles ahead of it
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_spans(r);
    endtask

    // let every expected span arrive and the block fall quiet
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_surface(input int w, input int h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= CFG_DATA_W'(w);
        @(posedge i_clk);
        surf_w_reg  = DIM_W'(w);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= CFG_DATA_W'(h);
        @(posedge i_clk);
        surf_h_reg  = DIM_W'(h);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_req make_req(input logic [OP_W-1:0] op, input int x, input int y,
                                      input int e, input int w, input int h,
                                      input int sub, input logic [COLOR_W-1:0] colour);
        t_req r;
        r.opcode       = op;
        r.pos_x        = COORD_W'(x);
        r.pos_y        = COORD_W'(y);
        r.end_coord    = COORD_W'(e);
        r.rect_w       = RW_W'(w);
        r.rect_h       = RW_W'(h);
        r.subdivisions = SUB_W'(sub);
        r.color        = colour;
        return r;
    endfunction

    // coordinates mostly near the surface so clipping edges get hit
    function automatic int near_coord(input int d);
        return int'($urandom_range(d + 127)) - 64;
    endfunction

    function automatic logic [RW_W-1:0] random_size(input int d);
        case ($urandom_range(9))
            0:       return RW_W'($urandom());
            1, 2:    return RW_W'($urandom_range(40));
            default: return RW_W'($urandom_range(d + 32));
        endcase
    endfunction

    function automatic t_req random_req();
        t_req r;
        int w, h;
        w = eff_dim(surf_w_reg);
        h = eff_dim(surf_h_reg);
        if ($urandom_range(99) < 5)
            r.opcode = OP_W'($urandom_range(int'(OP_GRID) + 1, (1 << OP_W) - 1));
        else
            r.opcode = OP_W'($urandom_range(int'(OP_DOT), int'(OP_GRID)));
        r.pos_x = ($urandom_range(99) < 15) ? COORD_W'($urandom()) : COORD_W'(near_coord(w));
        r.pos_y = ($urandom_range(99) < 15) ? COORD_W'($urandom()) : COORD_W'(near_coord(h));
        if ($urandom_range(99) < 15)
            r.end_coord = COORD_W'($urandom());
        else
            r.end_coord = COORD_W'(near_coord((r.opcode == OP_VL) ? h : w));
        r.rect_w       = random_size(w);
        r.rect_h       = random_size(h);
        r.subdivisions = SUB_W'($urandom());
        r.color        = $urandom();
        return r;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(5))
            0:       return 1;
            1:       return MAX_DIM;
            2:       return $urandom_range(1, 64);
            5:       return $urandom_range(0, (1 << DIM_W) - 1);
            default: return $urandom_range(1, MAX_DIM);
        endcase
    endfunction

    // dots, lines, rectangle outlines and unused opcodes at the reset surface size
    task automatic test_basic_shapes();
        send_req(make_req(OP_DOT, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_req(make_req(OP_DOT, 1023, 1023, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_req(make_req(OP_DOT, -1, 5, 0, 0, 0, 0, 32'h1234_5678));
        send_req(make_req(OP_DOT, 32767, -32768, 0, 0, 0, 0, 32'h0000_0001));
        // reversed ends, left end clamped
        send_req(make_req(OP_HL, 5, 10, -100, 0, 0, 0, 32'hA5A5_A5A5));
        // row above the surface is dropped
        send_req(make_req(OP_HL, 0, -1, 100, 0, 0, 0, 32'h5A5A_5A5A));
        // wholly off the right side still leaves one edge pixel
        send_req(make_req(OP_HL, 2000, 3, 3000, 0, 0, 0, 32'h0F0F_0F0F));
        send_req(make_req(OP_VL, 1023, -32768, 32767, 0, 0, 0, 32'hF0F0_F0F0));
        send_req(make_req(OP_VL, 1024, 0, 10, 0, 0, 0, 32'h8000_0000));
        send_req(make_req(OP_RECT, 10, 20, 0, 100, 50, 0, 32'hDEAD_BEEF));
        send_req(make_req(OP_RECT, -5, -5, 0, 20, 20, 0, 32'hCAFE_F00D));
        send_req(make_req(OP_RECT, 3, 3, 0, 0, 0, 0, 32'h0000_FFFF));
        // nothing visible at all
        send_req(make_req(OP_RECT, -32768, -32768, 0, 32767, 32767, 0, 32'hFFFF_0000));
        // opcodes with no meaning give nothing
        for (int op = int'(OP_GRID) + 1; op < (1 << OP_W); op++)
            send_req(make_req(OP_W'(op), 1, 1, 1, 1, 1, 1, 32'h1111_1111));
    endtask

    task automatic test_grids();
        // zero subdivisions and a zero step both give the error result
        send_req(make_req(OP_GRID, 0, 0, 0, 100, 100, 0, 32'h2222_2222));
        send_req(make_req(OP_GRID, 0, 0, 0, 3, 100, 4, 32'h3333_3333));
        send_req(make_req(OP_GRID, 0, 0, 0, 100, 80, 4, 32'h4444_4444));
        // unit step on both axes, the most spans a request can give
        send_req(make_req(OP_GRID, 0, 0, 0, 29, 29, 15, 32'h5555_5555));
        send_req(make_req(OP_GRID, 32767, 32767, 0, 32767, 32767, 15, 32'h6666_6666));
    endtask

    // empty, saturated and single-pixel surfaces
    task automatic test_surface_limits();
        wait_drained();
        set_surface(0, int'(SURF_RESET));
        send_req(make_req(OP_DOT, 0, 0, 0, 0, 0, 0, 32'h7777_7777));
        send_req(make_req(OP_GRID, 0, 0, 0, 9, 9, 0, 32'h8888_8888));
        wait_drained();
        set_surface((1 << DIM_W) - 1, (1 << DIM_W) - 1);
        send_req(make_req(OP_HL, -5, 4095, 5000, 0, 0, 0, 32'h9999_9999));
        send_req(make_req(OP_DOT, 4095, 4095, 0, 0, 0, 0, 32'hAAAA_AAAA));
        wait_drained();
        set_surface(1, 1);
        send_req(make_req(OP_DOT, 0, 0, 0, 0, 0, 0, 32'hBBBB_BBBB));
        send_req(make_req(OP_RECT, 0, 0, 0, 5, 5, 0, 32'hCCCC_CCCC));
    endtask

    task automatic test_random_traffic(input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (SETTINGS_PER) begin
            wait_drained();
            set_surface(pick_dim(), pick_dim());
            repeat (ITEMS_PER) send_req(random_req());
        end
    endtask

    // compare each span transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_span_valid) begin
            if (pending_spans.size() == 0) begin
                report_mismatch("span transfer with none expected");
            end else begin
                want = pending_spans.pop_front();
                if (o_span.span_x !== want.span_x)
                    report_mismatch($sformatf("span_x %0d, expected %0d",
                                              o_span.span_x, want.span_x));
                if (o_span.span_y !== want.span_y)
                    report_mismatch($sformatf("span_y %0d, expected %0d",
                                              o_span.span_y, want.span_y));
                if (o_span.span_len !== want.span_len)
                    report_mismatch($sformatf("span_len %0d, expected %0d",
                                              o_span.span_len, want.span_len));
                if (o_span.vertical !== want.vertical)
                    report_mismatch($sformatf("vertical %b, expected %b",
                                              o_span.vertical, want.vertical));
                if (o_span.span_color !== want.span_color)
                    report_mismatch($sformatf("span_color %h, expected %h",
                                              o_span.span_color, want.span_color));
                if (o_span.bad_request !== want.bad_request)
                    report_mismatch($sformatf("bad_request %b, expected %b",
                                              o_span.bad_request, want.bad_request));
                if (o_span.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_span.last, want.last));
            end
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 21;
        test_basic_shapes();
        test_grids();
        test_surface_limits();
        test_random_traffic(21);
        test_random_traffic(68);
        test_random_traffic(0);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("clipped_axis_line_span_generator_unit_tb OK");
        end else begin
            $display("clipped_axis_line_span_generator_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/csg_pkg.sv
rtl/csg_ctrl.sv
rtl/csg_dpath.sv
rtl/clipped_axis_line_span_generator_unit.sv
tb/clipped_axis_line_span_generator_unit_tb.sv
